### src/tccw_pkg.sv
// Package: shared types, codes and constants of the text console writer.
package tccw_pkg;

  // Field widths of the transactions
  localparam int OPCODE_W    = 1;
  localparam int CHAR_W      = 8;
  localparam int READ_ROW_W  = 5;
  localparam int READ_COL_W  = 7;
  localparam int CELL_W      = 16;
  localparam int ATTR_W      = 8;

  typedef logic [READ_ROW_W-1:0] row_field_t;
  typedef logic [READ_COL_W-1:0] col_field_t;
  typedef logic [CELL_W-1:0]     cell_t;
  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [ATTR_W-1:0]     attr_t;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_PUT  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

  // Control characters
  localparam char_t CH_BS  = 8'd8;
  localparam char_t CH_TAB = 8'd9;
  localparam char_t CH_LF  = 8'd10;
  localparam char_t CH_CR  = 8'd13;

  localparam char_t SPACE_CHAR = 8'h20;
  localparam attr_t ATTR_RESET = 8'h04;

  // Memory strobes from the sequencer
  typedef struct packed {
    logic we;
    logic re;
  } mem_cmd_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic clearing;
    logic busy;
  } stat_t;

  function automatic cell_t make_cell(input char_t ch, input attr_t attr);
    return {attr, ch};
  endfunction

endpackage

### src/tccw_if.sv
// Interfaces: input, result and configuration channels.
interface tccw_in_if;
  import tccw_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  char_t               char_code;
  row_field_t          read_row;
  col_field_t          read_col;
  modport source (output valid, output opcode, output char_code, output read_row,
                  output read_col, input ready);
  modport sink   (input valid, input opcode, input char_code, input read_row,
                  input read_col, output ready);
endinterface

interface tccw_out_if;
  import tccw_pkg::*;
  logic       valid;
  logic       ready;
  cell_t      cell_word;
  row_field_t cursor_row;
  col_field_t cursor_col;
  logic       scrolled;
  modport source (output valid, output cell_word, output cursor_row, output cursor_col,
                  output scrolled, input ready);
  modport sink   (input valid, input cell_word, input cursor_row, input cursor_col,
                  input scrolled, output ready);
endinterface

interface tccw_cfg_if;
  import tccw_pkg::*;
  logic  valid;
  logic  ready;
  attr_t text_attribute;
  modport source (output valid, output text_attribute, input ready);
  modport sink   (input valid, input text_attribute, output ready);
endinterface

### src/text_console_char_writer.sv
// Top level: text console character writer with screen memory.
//
//   channel | dir | handshake      | payload
//   in_ch   | in  | valid / ready  | opcode, char_code, read_row, read_col
//   out_ch  | out | valid / ready  | cell_word, cursor_row, cursor_col, scrolled
//   cfg_ch  | in  | valid / ready  | text_attribute (ready always high)
//
// A printable byte or backspace is decoded, row mapped, written and loaded as a
// result; no new item is taken until it is done. An in-range read adds a
// registered memory read, a tab one write per padded cell; newline, carriage
// return and out-of-range reads skip mapping and access. A scroll blanks the
// SCREEN_COLS cells of the old top row. A clearing pass over SCREEN_ROWS*SCREEN_COLS
// cells (2000) follows reset; a held result stalls an item only as it finishes.
module text_console_char_writer #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int TAB_STOP    = 4
) (
  input logic         clk,
  input logic         rst_n,
  tccw_in_if.sink     in_ch,
  tccw_out_if.source  out_ch,
  tccw_cfg_if.sink    cfg_ch
);
  import tccw_pkg::*;

  localparam int DEPTH = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW    = $clog2(DEPTH);

  attr_t         attr_r, attr_nxt;
  mem_cmd_t      mem_cmd;
  logic [AW-1:0] mem_addr;
  cell_t         mem_wdata;
  cell_t         mem_rdata;
  stat_t         stat;

  // Hold the attribute register
  assign cfg_ch.ready = 1'b1;
  assign attr_nxt     = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.text_attribute : attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  tccw_ctrl #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .TAB_STOP    (TAB_STOP),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .attr      (attr_r),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .stat      (stat)
  );

  tccw_screen_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // No transaction taken during the clearing pass
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_ch.ready)
    else $error("input taken during clearing pass");

  // An accepted transaction keeps the sequencer busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> stat.busy)
    else $error("sequencer idle after accepting a transaction");

  // The single memory port never reads and writes at once
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_cmd.we && mem_cmd.re))
    else $error("memory read and write in the same cycle");

  // A scroll leaves the cursor on the bottom row
  a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.scrolled) |->
      (32'(out_ch.cursor_row) == ((SCREEN_ROWS - 1) % 32)) && (out_ch.cursor_col == '0))
    else $error("scroll result not at bottom row, column zero");

endmodule

### src/tccw_screen_ram.sv
// Screen cell memory: one synchronous port, registered read data.
module tccw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                  clk,
  input  tccw_pkg::mem_cmd_t    cmd,
  input  logic [AW-1:0]         addr,
  input  tccw_pkg::cell_t       wdata,
  output tccw_pkg::cell_t       rdata
);
  import tccw_pkg::*;

  cell_t mem [DEPTH];
  cell_t rdata_r;

  // Write the cell
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[addr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (cmd.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/tccw_ctrl.sv
// Sequencer: cursor state, screen access steps, scroll and clearing sweeps.
module tccw_ctrl #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int TAB_STOP    = 4,
  parameter int AW          = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  tccw_in_if.sink            in_ch,
  tccw_out_if.source         out_ch,
  input  tccw_pkg::attr_t    attr,
  output tccw_pkg::mem_cmd_t mem_cmd,
  output logic [AW-1:0]      mem_addr,
  output tccw_pkg::cell_t    mem_wdata,
  input  tccw_pkg::cell_t    mem_rdata,
  output tccw_pkg::stat_t    stat
);
  import tccw_pkg::*;

  localparam int ROW_W = $clog2(SCREEN_ROWS);
  localparam int COL_W = $clog2(SCREEN_COLS);
  localparam int PH_W  = $clog2(TAB_STOP);
  localparam int DEPTH = SCREEN_ROWS * SCREEN_COLS;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLS - 1);
  localparam logic [PH_W-1:0]  LAST_PH  = PH_W'(TAB_STOP - 1);
  localparam logic [PH_W-1:0]  EOL_PH   = PH_W'((SCREEN_COLS - 1) % TAB_STOP);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_PHYS   = 8'b0000_1000,
    S_ACCESS = 8'b0001_0000,
    S_RDATA  = 8'b0010_0000,
    S_SCROLL = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic [OPCODE_W-1:0] op_r, op_nxt;
  char_t               ch_r, ch_nxt;
  row_field_t          rrow_r, rrow_nxt;
  col_field_t          rcol_r, rcol_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [PH_W-1:0]     phase_r, phase_nxt;
  logic [ROW_W-1:0]    top_r, top_nxt;
  logic [ROW_W-1:0]    tgt_row_r, tgt_row_nxt;
  logic [COL_W-1:0]    tgt_col_r, tgt_col_nxt;
  logic [ROW_W-1:0]    phys_r, phys_nxt;
  logic                scr_r, scr_nxt;
  cell_t               cell_r, cell_nxt;
  logic                out_valid_r, out_valid_nxt;
  cell_t               out_cell_r, out_cell_nxt;
  row_field_t          out_row_r, out_row_nxt;
  col_field_t          out_col_r, out_col_nxt;
  logic                out_scr_r, out_scr_nxt;

  logic                accept;
  logic [ROW_W:0]      phys_sum;
  logic [PH_W-1:0]     ph_inc, ph_dec;
  logic                in_range;
  logic                is_tab, blank_wr;

  assign accept   = in_ch.valid && in_ch.ready;
  assign phys_sum = {1'b0, top_r} + {1'b0, tgt_row_r};
  assign ph_inc   = (phase_r == LAST_PH) ? '0 : phase_r + 1'b1;
  assign ph_dec   = (phase_r == '0) ? LAST_PH : phase_r - 1'b1;
  assign in_range = (32'(rrow_r) < SCREEN_ROWS) && (32'(rcol_r) < SCREEN_COLS);
  assign is_tab   = (ch_r == CH_TAB);
  assign blank_wr = (ch_r == CH_TAB) || (ch_r == CH_BS);

  // Drive the memory port
  always_comb begin
    mem_cmd.we = 1'b0;
    mem_cmd.re = 1'b0;
    if (state_r == S_CLEAR) begin
      mem_addr  = clr_addr_r;
      mem_wdata = make_cell(SPACE_CHAR, ATTR_RESET);
      mem_cmd.we = 1'b1;
    end else begin
      mem_addr  = AW'(AW'(phys_r) * AW'(SCREEN_COLS) + AW'(tgt_col_r));
      mem_wdata = (state_r == S_SCROLL || blank_wr) ? make_cell(SPACE_CHAR, attr)
                                                     : make_cell(ch_r, attr);
      if (state_r == S_SCROLL) begin
        mem_cmd.we = 1'b1;
      end else if (state_r == S_ACCESS) begin
        mem_cmd.we = (op_r == OP_PUT);
        mem_cmd.re = (op_r == OP_READ);
      end
    end
  end

  // Advance the sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    op_nxt       = op_r;
    ch_nxt       = ch_r;
    rrow_nxt     = rrow_r;
    rcol_nxt     = rcol_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    phase_nxt    = phase_r;
    top_nxt      = top_r;
    tgt_row_nxt  = tgt_row_r;
    tgt_col_nxt  = tgt_col_r;
    phys_nxt     = phys_r;
    scr_nxt      = scr_r;
    cell_nxt     = cell_r;
    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_ch.opcode;
          ch_nxt    = in_ch.char_code;
          rrow_nxt  = in_ch.read_row;
          rcol_nxt  = in_ch.read_col;
          scr_nxt   = 1'b0;
          cell_nxt  = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        tgt_row_nxt = row_r;
        tgt_col_nxt = col_r;
        if (op_r == OP_READ) begin
          tgt_row_nxt = ROW_W'(rrow_r);
          tgt_col_nxt = COL_W'(rcol_r);
          state_nxt   = in_range ? S_PHYS : S_DONE;
        end else begin
          case (ch_r)
            CH_LF: begin
              col_nxt   = '0;
              phase_nxt = '0;
              if (row_r == LAST_ROW) begin
                phys_nxt    = top_r;
                tgt_col_nxt = '0;
                scr_nxt     = 1'b1;
                state_nxt   = S_SCROLL;
              end else begin
                row_nxt   = row_r + 1'b1;
                state_nxt = S_DONE;
              end
            end
            CH_CR: begin
              col_nxt   = '0;
              phase_nxt = '0;
              state_nxt = S_DONE;
            end
            CH_BS: begin
              if (col_r != '0) begin
                col_nxt     = col_r - 1'b1;
                phase_nxt   = ph_dec;
                tgt_col_nxt = col_r - 1'b1;
                state_nxt   = S_PHYS;
              end else if (row_r != '0) begin
                row_nxt     = row_r - 1'b1;
                col_nxt     = LAST_COL;
                phase_nxt   = EOL_PH;
                tgt_row_nxt = row_r - 1'b1;
                tgt_col_nxt = LAST_COL;
                state_nxt   = S_PHYS;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_PHYS;
            end
          endcase
        end
      end
      S_PHYS: begin
        // Map the screen row onto the stored row
        phys_nxt  = (phys_sum >= (ROW_W+1)'(SCREEN_ROWS))
                    ? ROW_W'(phys_sum - (ROW_W+1)'(SCREEN_ROWS)) : ROW_W'(phys_sum);
        state_nxt = S_ACCESS;
      end
      S_ACCESS: begin
        if (op_r == OP_READ) begin
          state_nxt = S_RDATA;
        end else if (ch_r == CH_BS) begin
          state_nxt = S_DONE;
        end else if (col_r == LAST_COL) begin
          // Wrap to the next row, scrolling from the bottom row
          col_nxt   = '0;
          phase_nxt = '0;
          if (row_r == LAST_ROW) begin
            phys_nxt    = top_r;
            tgt_col_nxt = '0;
            scr_nxt     = 1'b1;
            state_nxt   = S_SCROLL;
          end else begin
            row_nxt   = row_r + 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          col_nxt   = col_r + 1'b1;
          phase_nxt = ph_inc;
          if (is_tab && ph_inc != '0) begin
            tgt_col_nxt = col_r + 1'b1;
            state_nxt   = S_ACCESS;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RDATA: begin
        cell_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end
      S_SCROLL: begin
        // Blank the old top row, then rotate the top
        if (tgt_col_r == LAST_COL) begin
          top_nxt   = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          tgt_col_nxt = tgt_col_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Load the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cell_nxt  = out_cell_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_scr_nxt   = out_scr_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_valid_nxt = 1'b1;
      out_cell_nxt  = cell_r;
      out_row_nxt   = row_field_t'(row_r);
      out_col_nxt   = col_field_t'(col_r);
      out_scr_nxt   = scr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      phase_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      phase_r     <= phase_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ch_r       <= ch_nxt;
    rrow_r     <= rrow_nxt;
    rcol_r     <= rcol_nxt;
    tgt_row_r  <= tgt_row_nxt;
    tgt_col_r  <= tgt_col_nxt;
    phys_r     <= phys_nxt;
    scr_r      <= scr_nxt;
    cell_r     <= cell_nxt;
    out_cell_r <= out_cell_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.cell_word = out_cell_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.scrolled  = out_scr_r;

  assign stat.clearing = (state_r == S_CLEAR);
  assign stat.busy     = (state_r != S_IDLE) && (state_r != S_CLEAR);

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench: directed and random traffic on the console writer, checked by a screen predictor.
module tb_top;
  import tccw_pkg::*;

  localparam int COLS           = 80;
  localparam int ROWS           = 25;
  localparam int TAB_STOP       = 4;
  localparam int IDLE_PCT       = 23;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 120;   // longest item: a scroll plus a padded tab
  localparam int WATCHDOG_LIMIT = 12000; // covers the clearing pass and a held result
  localparam int RANDOM_ITEMS   = 1728;
  localparam int PRINT_LIMIT    = 100;

  typedef struct packed {
    cell_t      cell_word;
    row_field_t cursor_row;
    col_field_t cursor_col;
    logic       scrolled;
  } console_result_t;

  logic clk = 1'b0;
  logic rst_n;

  tccw_in_if  in_ch ();
  tccw_out_if out_ch ();
  tccw_cfg_if cfg_ch ();

  text_console_char_writer #(
    .SCREEN_COLS (COLS),
    .SCREEN_ROWS (ROWS),
    .TAB_STOP    (TAB_STOP)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // Screen predictor state
  cell_t       screen_mem [ROWS*COLS];
  int unsigned top_row;
  int unsigned cur_row;
  int unsigned cur_col;
  attr_t       text_attr;
  logic        scroll_flag;

  console_result_t expected_cells_q [$];
  console_result_t oldest_expected;

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned reads_sent;
  int unsigned scrolls_sent;
  int unsigned attr_writes;
  int unsigned hold_requests;
  int unsigned hold_served;
  int          stall_cycles;
  bit          no_idle;

  function automatic cell_t blank_cell();
    return {text_attr, SPACE_CHAR};
  endfunction

  // Map a visible row to its stored row through the scroll offset
  function automatic int unsigned screen_addr(int unsigned row, int unsigned col);
    return ((top_row + row) % ROWS) * COLS + col;
  endfunction

  // Go to column 0 of the next row, scrolling when past the bottom
  function automatic void move_to_next_row();
    cur_col = 0;
    if (cur_row + 1 >= ROWS) begin
      for (int c = 0; c < COLS; c++) screen_mem[top_row*COLS + c] = blank_cell();
      top_row     = (top_row + 1) % ROWS;
      scroll_flag = 1'b1;
      cur_row     = ROWS - 1;
    end else begin
      cur_row++;
    end
  endfunction

  function automatic void write_at_cursor(char_t ch);
    screen_mem[screen_addr(cur_row, cur_col)] = {text_attr, ch};
    cur_col++;
    if (cur_col >= COLS) move_to_next_row();
  endfunction

  // Apply one transaction to the screen state and return the result it yields
  function automatic console_result_t predict_console(logic [OPCODE_W-1:0] op, char_t ch,
                                                      row_field_t rrow, col_field_t rcol);
    console_result_t res;
    res.cell_word = '0;
    scroll_flag   = 1'b0;
    if (op == OP_PUT) begin
      case (ch)
        CH_LF: move_to_next_row();
        CH_CR: cur_col = 0;
        CH_BS: begin
          // nothing to erase at the home position
          if (cur_col > 0 || cur_row > 0) begin
            if (cur_col > 0) begin
              cur_col--;
            end else begin
              cur_row--;
              cur_col = COLS - 1;
            end
            screen_mem[screen_addr(cur_row, cur_col)] = blank_cell();
          end
        end
        CH_TAB: begin
          write_at_cursor(SPACE_CHAR);
          while (cur_col % TAB_STOP != 0) write_at_cursor(SPACE_CHAR);
        end
        default: write_at_cursor(ch);
      endcase
    end else if (rrow < ROWS && rcol < COLS) begin
      res.cell_word = screen_mem[screen_addr(rrow, rcol)];
    end
    res.cursor_row = row_field_t'(cur_row);
    res.cursor_col = col_field_t'(cur_col);
    res.scrolled   = scroll_flag;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (error_count < PRINT_LIMIT)
      $display("tb: mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Offer one transaction, idling first at random; valid stays high after acceptance
  task automatic send_item(logic [OPCODE_W-1:0] op, char_t ch, row_field_t rrow,
                           col_field_t rcol);
    console_result_t res;
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.char_code <= ch;
    in_ch.read_row  <= rrow;
    in_ch.read_col  <= rcol;
    do @(posedge clk); while (!in_ch.ready);
    res = predict_console(op, ch, rrow, rcol);
    expected_cells_q.push_back(res);
    items_sent++;
    if (op == OP_READ) reads_sent++;
    if (res.scrolled) scrolls_sent++;
  endtask

  task automatic put_char(char_t ch);
    send_item(OP_PUT, ch, row_field_t'($urandom), col_field_t'($urandom));
  endtask

  task automatic read_cell(row_field_t rrow, col_field_t rcol);
    send_item(OP_READ, char_t'($urandom), rrow, rcol);
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_cells_q.size() != 0);
  endtask

  task automatic set_attribute(attr_t attr);
    wait_drained();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.text_attribute <= attr;
    do @(posedge clk); while (!cfg_ch.ready);
    text_attr = attr;
    attr_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  // Field extremes, out-of-range reads and every control byte at reset attribute
  task automatic test_directed();
    read_cell(5'd24, 7'd79);
    read_cell(5'd25, 7'd0);
    read_cell(5'd0, 7'd80);
    read_cell(5'd31, 7'd127);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    read_cell(5'd0, 7'd0);
    put_char(CH_BS);
    put_char(CH_TAB);
    put_char(CH_TAB);
    put_char(CH_CR);
    put_char(CH_BS);   // at home: no effect
    put_char(CH_LF);
    put_char(CH_BS);   // back onto the end of the row above
    put_char(CH_TAB);  // tab at the last column wraps and stops
    put_char(8'h7E);
    read_cell(5'd1, 7'd0);
    read_cell(5'd0, 7'd79);
  endtask

  // Reach the bottom row, then scroll by newline, by wrap and by a wrapping tab
  task automatic test_scrolling();
    repeat (30) put_char(CH_LF);
    repeat (COLS) put_char(char_t'($urandom_range(33, 126)));
    repeat (COLS - 1) put_char(char_t'($urandom_range(33, 126)));
    put_char(CH_TAB);
    put_char(CH_BS);
    repeat (5) put_char(char_t'($urandom_range(33, 126)));
    for (int r = ROWS - 3; r < ROWS; r++) begin
      read_cell(row_field_t'(r), 7'd0);
      read_cell(row_field_t'(r), 7'd79);
      read_cell(row_field_t'(r), col_field_t'($urandom_range(COLS - 1)));
    end
  endtask

  // Walk the attribute through its extremes and mixed bit patterns
  task automatic test_attribute_sweep();
    attr_t sweep [4];
    sweep = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
    foreach (sweep[i]) begin
      set_attribute(sweep[i]);
      put_char(char_t'($urandom));
      put_char(CH_TAB);
      put_char(CH_BS);
      put_char(CH_LF);
      read_cell(row_field_t'(cur_row), 7'd0);
      read_cell(row_field_t'(cur_row), col_field_t'($urandom_range(COLS - 1)));
      read_cell(row_field_t'($urandom_range(ROWS - 1)), col_field_t'($urandom_range(COLS - 1)));
    end
  endtask

  // Hold the result channel off while the sender keeps offering
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_requests++;
    repeat (20) put_char(char_t'($urandom));
    read_cell(row_field_t'(cur_row), col_field_t'($urandom_range(COLS - 1)));
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Mostly text with control bytes and reads; attribute changes per phase
  task automatic test_random_traffic();
    int unsigned pick;
    char_t       ch;
    row_field_t  rrow;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) set_attribute(attr_t'($urandom_range(255)));
      no_idle = (phase == 2);
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          // reads: near the cursor, anywhere visible, or out of range
          if (pick < 10) rrow = row_field_t'(cur_row);
          else if (pick < 22) rrow = row_field_t'($urandom_range(ROWS - 1));
          else rrow = row_field_t'($urandom);
          if (pick >= 22) read_cell(rrow, col_field_t'($urandom));
          else read_cell(rrow, col_field_t'($urandom_range(COLS - 1)));
        end else begin
          case ($urandom_range(19))
            0:       ch = CH_LF;
            1:       ch = CH_CR;
            2, 3:    ch = CH_BS;
            4:       ch = CH_TAB;
            5:       ch = char_t'($urandom);
            default: ch = char_t'($urandom_range(32, 126));
          endcase
          put_char(ch);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // Result channel ready: random stalls, or a counted hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_cells_q.size() == 0) begin
        report_mismatch("unexpected result", out_ch.cell_word, 0);
      end else begin
        oldest_expected = expected_cells_q.pop_front();
        if (out_ch.cell_word !== oldest_expected.cell_word)
          report_mismatch("cell_word", out_ch.cell_word, oldest_expected.cell_word);
        if (out_ch.cursor_row !== oldest_expected.cursor_row)
          report_mismatch("cursor_row", out_ch.cursor_row, oldest_expected.cursor_row);
        if (out_ch.cursor_col !== oldest_expected.cursor_col)
          report_mismatch("cursor_col", out_ch.cursor_col, oldest_expected.cursor_col);
        if (out_ch.scrolled !== oldest_expected.scrolled)
          report_mismatch("scrolled", out_ch.scrolled, oldest_expected.scrolled);
      end
    end
  end

  // Abort when no channel moves a transaction for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    error_count   = 0;
    items_sent    = 0;
    reads_sent    = 0;
    scrolls_sent  = 0;
    attr_writes   = 0;
    hold_requests = 0;
    hold_served   = 0;
    stall_cycles  = 0;
    no_idle       = 1'b0;
    text_attr     = ATTR_RESET;
    top_row       = 0;
    cur_row       = 0;
    cur_col       = 0;
    scroll_flag   = 1'b0;
    for (int i = 0; i < ROWS*COLS; i++) screen_mem[i] = {ATTR_RESET, SPACE_CHAR};

    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.opcode          <= OP_PUT;
    in_ch.char_code       <= '0;
    in_ch.read_row        <= '0;
    in_ch.read_col        <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.text_attribute <= ATTR_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_scrolling();
    test_attribute_sweep();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d transactions (%0d reads), %0d scrolls, %0d attribute writes",
             items_sent, reads_sent, scrolls_sent, attr_writes);
    $display("tb: covered control bytes, wraps, scrolls, out-of-range reads, %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
